/* sv/dswg_pkg.sv */
// Shared types, constants and helper functions for the DDS sweep word generator.
// Used by all modules of the block; has no dependencies of its own.
package dswg_pkg;

  localparam int unsigned HzW        = 24;
  localparam int unsigned TwW        = 32;
  localparam int unsigned WordW      = 16;
  localparam int unsigned BcdW       = 28;
  localparam int unsigned StepW      = 8;
  localparam int unsigned DwellW     = 16;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned ProdW      = 55;
  localparam int unsigned TwShift    = 24;

  localparam logic [30:0]    TwMul     = 31'd1441151881;
  localparam logic [HzW-1:0] InitHz    = 24'd1000;
  localparam logic [HzW-1:0] StartRst  = 24'd10;
  localparam logic [HzW-1:0] EndRst    = 24'd1000000;
  localparam logic [StepW-1:0] StepRst = 8'd100;
  localparam logic [DwellW-1:0] DwellRst = 16'd10000;

  localparam logic [3:0] InitLastIdx = 4'd10;
  localparam logic [3:0] FreqLastIdx = 4'd3;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DIGITS = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_STEP  = 2'd2,
    REG_DWELL = 2'd3
  } reg_e;

  typedef struct packed {
    logic [HzW-1:0]    start;
    logic [HzW-1:0]    stop;
    logic [StepW-1:0]  step;
    logic [DwellW-1:0] dwell;
  } cfg_t;

  typedef struct packed {
    logic           init;
    logic [HzW-1:0] hz;
  } job_t;

  function automatic logic [HzW-1:0] bcd_to_hz(input logic [BcdW-1:0] bcd);
    logic [HzW-1:0] hz;
    logic [3:0]     d;
    hz = '0;
    for (int i = 6; i >= 0; i--) begin
      d = bcd[4*i +: 4];
      if (d > 4'd9) begin
        d = 4'd0;
      end
      hz = HzW'(hz * HzW'(10)) + HzW'(d);
    end
    return hz;
  endfunction

  function automatic logic [TwW-1:0] hz_to_tw(input logic [HzW-1:0] hz);
    logic [ProdW-1:0] prod;
    prod = ProdW'(hz) * ProdW'(TwMul);
    return TwW'(prod >> TwShift);
  endfunction

  function automatic logic [WordW-1:0] dds_word(input logic init, input logic [3:0] idx,
                                                input logic [TwW-1:0] tw);
    logic [3:0]       fidx;
    logic [WordW-1:0] w;
    fidx = init ? 4'(idx - 4'd6) : idx;
    w    = 16'hC000;
    if (init && idx < 4'd6) begin
      unique case (idx[2:0])
        3'd0:    w = 16'hF800;
        3'd1:    w = 16'hB000;
        3'd2:    w = 16'h5000;
        3'd3:    w = 16'h4000;
        3'd4:    w = 16'h1800;
        3'd5:    w = 16'h0900;
        default: w = 16'hC000;
      endcase
    end else if (!init || idx < InitLastIdx) begin
      unique case (fidx[1:0])
        2'd0:    w = {8'h30, tw[7:0]};
        2'd1:    w = {8'h21, tw[15:8]};
        2'd2:    w = {8'h32, tw[23:16]};
        default: w = {8'h23, tw[31:24]};
      endcase
    end
    return w;
  endfunction

endpackage

/* sv/dds_sweep_word_generator_unit.sv */
// Top level of the DDS sweep word generator: APB register file, front end, job queue, back end.
// Depends on dswg_pkg, dswg_front, dswg_queue and dswg_back.
//
// Channel   Direction  Handshake                   Payload
// request   in         in_valid_i / in_stall_o     cmd_i, bcd_digits_i
// word      out        out_valid_o / out_stall_i   dds_word_o, last_word_o
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// A request is taken whenever the job queue has room.
// The output register sends one word per cycle while out_stall_i is low: four words per
// frequency update, eleven for the init sequence; a tick without a step makes no words.
// Output stalls back up through the queue to in_stall_o. Reset clears the sweep
// state and loads the register defaults; no clearing pass is needed.
module dds_sweep_word_generator_unit import dswg_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [BcdW-1:0]     bcd_digits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordW-1:0]    dds_word_o,
  output logic                last_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg_q;
  logic wr_en;
  reg_e sel;
  logic push, full, pop, empty;
  job_t job, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[3:2]);

  always_comb begin
    unique case (sel)
      REG_START: prdata = ApbDataW'(cfg_q.start);
      REG_END:   prdata = ApbDataW'(cfg_q.stop);
      REG_STEP:  prdata = ApbDataW'(cfg_q.step);
      default:   prdata = ApbDataW'(cfg_q.dwell);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start <= StartRst;
      cfg_q.stop  <= EndRst;
      cfg_q.step  <= StepRst;
      cfg_q.dwell <= DwellRst;
    end else if (wr_en) begin
      unique case (sel)
        REG_START: cfg_q.start <= pwdata[HzW-1:0];
        REG_END:   cfg_q.stop  <= pwdata[HzW-1:0];
        REG_STEP:  cfg_q.step  <= pwdata[StepW-1:0];
        default:   cfg_q.dwell <= pwdata[DwellW-1:0];
      endcase
    end
  end

  dswg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .bcd_digits_i (bcd_digits_i),
    .q_full_i     (full),
    .push_o       (push),
    .job_o        (job)
  );

  dswg_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  dswg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dds_word_o  (dds_word_o),
    .last_word_o (last_word_o)
  );

endmodule

/* sv/dswg_front.sv */
// Front end: accepts command requests, keeps the sweep state and queues frequency jobs.
// Depends on dswg_pkg.
module dswg_front import dswg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      cmd_i,
  input  logic [BcdW-1:0] bcd_digits_i,
  input  logic            q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [HzW-1:0]    cur_q, cur_d;
  logic              up_q, up_d;
  logic              sweeping_q, sweeping_d;
  logic [DwellW-1:0] dwell_q, dwell_d;

  logic              accept;
  logic [DwellW-1:0] cnt;
  logic [HzW:0]      up_next;
  logic [HzW-1:0]    dn_next;
  logic              ok;
  cmd_e              cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cmd        = cmd_e'(cmd_i);
  assign cnt        = dwell_q + DwellW'(1);
  assign up_next    = {1'b0, cur_q} + (HzW + 1)'(cfg_i.step);
  assign dn_next    = cur_q - HzW'(cfg_i.step);
  assign ok         = up_q ? (up_next <= {1'b0, cfg_i.stop})
                           : (cur_q >= HzW'(cfg_i.step) && dn_next >= cfg_i.stop);

  always_comb begin
    cur_d       = cur_q;
    up_d        = up_q;
    sweeping_d  = sweeping_q;
    dwell_d     = dwell_q;
    push_o      = 1'b0;
    job_o.init  = 1'b0;
    job_o.hz    = cur_q;
    if (accept) begin
      unique case (cmd)
        CMD_INIT: begin
          cur_d      = InitHz;
          sweeping_d = 1'b0;
          dwell_d    = '0;
          push_o     = 1'b1;
          job_o.init = 1'b1;
          job_o.hz   = InitHz;
        end
        CMD_DIGITS: begin
          cur_d      = bcd_to_hz(bcd_digits_i);
          sweeping_d = 1'b0;
          dwell_d    = '0;
          push_o     = 1'b1;
          job_o.hz   = cur_d;
        end
        CMD_SWEEP: begin
          cur_d      = cfg_i.start;
          dwell_d    = '0;
          push_o     = 1'b1;
          job_o.hz   = cfg_i.start;
          sweeping_d = cfg_i.start != cfg_i.stop;
          if (cfg_i.start != cfg_i.stop) begin
            up_d = cfg_i.start < cfg_i.stop;
          end
        end
        default: begin
          if (sweeping_q) begin
            if (cnt >= cfg_i.dwell) begin
              dwell_d = '0;
              if (ok) begin
                cur_d    = up_q ? up_next[HzW-1:0] : dn_next;
                push_o   = 1'b1;
                job_o.hz = cur_d;
              end else begin
                sweeping_d = 1'b0;
              end
            end else begin
              dwell_d = cnt;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      up_q       <= 1'b0;
      sweeping_q <= 1'b0;
      dwell_q    <= '0;
    end else begin
      cur_q      <= cur_d;
      up_q       <= up_d;
      sweeping_q <= sweeping_d;
      dwell_q    <= dwell_d;
    end
  end

endmodule

/* sv/dswg_queue.sv */
// Small job queue between the front end and the word emitter.
// Depends on dswg_pkg for the job type.
module dswg_queue import dswg_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + PtrW'(1));
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* sv/dswg_back.sv */
// Back end: takes queued jobs, forms the tuning word and emits the programming words.
// Depends on dswg_pkg.
module dswg_back import dswg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  job_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] dds_word_o,
  output logic             last_word_o
);

  logic             active_q, init_q, out_valid_q, last_q;
  logic [TwW-1:0]   tw_q;
  logic [3:0]       idx_q;
  logic [WordW-1:0] word_q;
  logic             load, at_last, fin;

  assign load    = !out_valid_q || !out_stall_i;
  assign at_last = idx_q == (init_q ? InitLastIdx : FreqLastIdx);
  assign fin     = active_q && load && at_last;
  assign pop_o   = !q_empty_i && (!active_q || fin);

  assign out_valid_o = out_valid_q;
  assign dds_word_o  = word_q;
  assign last_word_o = last_q;

  always_ff @(posedge clk_i) begin
    if (load && active_q) begin
      word_q <= dds_word(init_q, idx_q, tw_q);
      last_q <= at_last;
    end
    if (pop_o) begin
      tw_q   <= hz_to_tw(head_i.hz);
      init_q <= head_i.init;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= active_q;
      end
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (fin) begin
        active_q <= 1'b0;
      end else if (load && active_q) begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

endmodule
